// ----- rtl/core/bmp_pixel_stream_blitter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// bmp pixel stream blitter assertion macros
// Shared concurrent assertion helpers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BMP_PIXEL_STREAM_BLITTER_UNIT_MACROS_SVH
`define BMP_PIXEL_STREAM_BLITTER_UNIT_MACROS_SVH

// same-cycle implication
`define BMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp blitter: same-cycle check failed");

// next-cycle implication
`define BMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp blitter: next-cycle check failed");

`endif

// ----- rtl/core/bmp_blit_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp blitter package
// Widths, codes and default parameters shared by the blitter files.
// ----------------------------------------------------------------------------
package bmp_blit_pkg;

    // payload widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 19;
    localparam int COLOR_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ORIGIN_W   = 16;
    localparam int DIM_W      = 13;
    localparam int DEPTH_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // signed screen coordinate before clipping
    localparam int COORD_W    = 18;
    // coordinate bits once inside the screen
    localparam int SCR_COORD_W = 12;

    // default parameters
    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int MAX_IMAGE_DIM_DEF = 4096;

    // supported depths
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 6'd24;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BITS   = 3'd4;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_WRITE     = 2'd0,
        ST_CLIPPED   = 2'd1,
        ST_BAD_DEPTH = 2'd2
    } status_t;

    // byte position inside a pixel
    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } phase_t;

endpackage

// ----- rtl/core/bmp_blit_if.sv -----
// ----------------------------------------------------------------------------
// bmp blitter stream interfaces
// Valid/ready channels for the pixel byte input and the framebuffer result.
// ----------------------------------------------------------------------------
interface bmp_in_if
    import bmp_blit_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              start_image;

    modport source (output valid, output pixel_byte, output start_image, input ready);
    modport sink   (input valid, input pixel_byte, input start_image, output ready);
endinterface

interface bmp_out_if
    import bmp_blit_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0] pixel_color;
    status_t            status;
    logic               image_done;

    modport source (output valid, output fb_address, output pixel_color,
                    output status, output image_done, input ready);
    modport sink   (input valid, input fb_address, input pixel_color,
                    input status, input image_done, output ready);
endinterface

// ----- rtl/core/bmp_pixel_stream_blitter_unit.sv -----
// ----------------------------------------------------------------------------
// bmp pixel stream blitter
// Unpacks BMP pixel-array bytes into ARGB words with framebuffer addresses.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in carries one pixel-array byte per beat, padding included; set
//   start_image on the first byte of each image. pixel_out carries at most
//   one beat per input byte: the framebuffer word address and ARGB color,
//   a clipped status, or an unsupported-depth status on the third byte.
//   Configuration (origin, size, depth) is written by the user through cfg_we,
//   cfg_index, cfg_data while no beat is in flight; the block does not check it.
// Timing:
//   one byte per cycle while pixel_out is not stalled. An accepted byte's
//   result goes through the result stage register, then the output register:
//   the byte stage updates the counters and color holds, the result stage
//   clips and forms row * width + column with a constant multiply.
// Reset:
//   counters clear, depth goes to 24 and the block ignores bytes until one
//   arrives with start_image set.
// Backpressure:
//   when pixel_out stalls, the result stage still takes one more beat, then
//   pixel_in.ready drops until the output register frees.
// ----------------------------------------------------------------------------
`include "bmp_pixel_stream_blitter_unit_macros.svh"

module bmp_pixel_stream_blitter_unit
    import bmp_blit_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bmp_in_if.sink                pixel_in,
    bmp_out_if.source             pixel_out
);

    localparam int PROD_W = SCR_COORD_W + DIM_W;
    localparam logic signed [COORD_W-1:0] SCR_W_S = COORD_W'(SCREEN_WIDTH);
    localparam logic signed [COORD_W-1:0] SCR_H_S = COORD_W'(SCREEN_HEIGHT);

    // configuration registers
    logic signed [ORIGIN_W-1:0] origin_x_reg;
    logic signed [ORIGIN_W-1:0] origin_y_reg;
    logic [DIM_W-1:0]           image_width_reg;
    logic [DIM_W-1:0]           image_height_reg;
    logic [DEPTH_W-1:0]         depth_bits_reg;

    // byte stage state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] blue_reg, blue_next;
    logic [BYTE_W-1:0] green_reg, green_next;
    logic [BYTE_W-1:0] red_reg, red_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [1:0]        pad_reg, pad_next;
    logic              stopped_reg, stopped_next;

    // result stage register
    logic                      s1_valid_reg, s1_valid_next;
    logic signed [COORD_W-1:0] s1_x_reg, s1_x_next;
    logic signed [COORD_W-1:0] s1_y_reg, s1_y_next;
    logic [COLOR_W-1:0]        s1_color_reg, s1_color_next;
    logic                      s1_done_reg, s1_done_next;
    logic                      s1_err_reg, s1_err_next;
    logic                      emit;

    // output register
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    status_t            out_status_reg, out_status_next;
    logic               out_done_reg;

    // handshake
    logic out_slot;
    logic s1_adv;
    logic in_ready;
    logic in_acc;

    // clamped image size and row padding
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [1:0]       three_w;
    logic [1:0]       row_pad;

    assign out_slot = !out_valid_reg || pixel_out.ready;
    assign s1_adv   = s1_valid_reg && out_slot;
    assign in_ready = !s1_valid_reg || out_slot;
    assign in_acc   = pixel_in.valid && in_ready;
    assign pixel_in.ready = in_ready;

    assign dim_w = (int'(image_width_reg) > MAX_IMAGE_DIM) ?
                   DIM_W'(MAX_IMAGE_DIM) : image_width_reg;
    assign dim_h = (int'(image_height_reg) > MAX_IMAGE_DIM) ?
                   DIM_W'(MAX_IMAGE_DIM) : image_height_reg;
    assign three_w = 2'({dim_w[0], 1'b0} + dim_w[1:0]);
    assign row_pad = (depth_bits_reg == DEPTH_24) ? 2'(2'd0 - three_w) : 2'd0;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            depth_bits_reg   <= DEPTH_24;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= ORIGIN_W'(cfg_data);
                REG_ORIGIN_Y:     origin_y_reg     <= ORIGIN_W'(cfg_data);
                REG_IMAGE_WIDTH:  image_width_reg  <= DIM_W'(cfg_data);
                REG_IMAGE_HEIGHT: image_height_reg <= DIM_W'(cfg_data);
                REG_DEPTH_BITS:   depth_bits_reg   <= DEPTH_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // byte stage: counters, color holds and pixel placement
    always_comb
    begin
        logic [DIM_W:0]            col_inc;
        logic [DIM_W:0]            row_inc;
        logic                      place;
        logic [BYTE_W-1:0]         alpha;
        phase_next    = phase_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        red_next      = red_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;
        stopped_next  = stopped_reg;
        emit          = 1'b0;
        place         = 1'b0;
        alpha         = '0;
        s1_err_next   = 1'b0;
        s1_done_next  = 1'b0;
        s1_color_next = '0;
        col_inc       = '0;
        row_inc       = '0;
        if (in_acc)
        begin
            if (pixel_in.start_image)
            begin
                phase_next   = PH_BLUE;
                col_next     = '0;
                row_next     = '0;
                pad_next     = '0;
                stopped_next = (dim_w == '0) || (dim_h == '0);
            end
            if (!stopped_next)
            begin
                if (pad_next != 2'd0)
                begin
                    pad_next = pad_next - 2'd1;
                end
                else
                begin
                    case (phase_next)
                        PH_BLUE:
                        begin
                            blue_next  = pixel_in.pixel_byte;
                            phase_next = PH_GREEN;
                        end
                        PH_GREEN:
                        begin
                            green_next = pixel_in.pixel_byte;
                            phase_next = PH_RED;
                        end
                        PH_RED:
                        begin
                            red_next = pixel_in.pixel_byte;
                            if (depth_bits_reg == DEPTH_24)
                            begin
                                phase_next = PH_BLUE;
                                place      = 1'b1;
                            end
                            else if (depth_bits_reg == DEPTH_32)
                            begin
                                phase_next = PH_ALPHA;
                            end
                            else
                            begin
                                phase_next   = PH_BLUE;
                                stopped_next = 1'b1;
                                emit         = 1'b1;
                                s1_err_next  = 1'b1;
                                s1_done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_BLUE;
                            alpha      = pixel_in.pixel_byte;
                            place      = 1'b1;
                        end
                    endcase
                end
            end
        end
        // coordinates use the counters as they stand before this pixel
        s1_x_next = COORD_W'(origin_x_reg) + COORD_W'(signed'({1'b0, col_next}));
        s1_y_next = COORD_W'(origin_y_reg) + COORD_W'(signed'({1'b0, dim_h}))
                    - COORD_W'(1) - COORD_W'(signed'({1'b0, row_next}));
        if (place)
        begin
            emit          = 1'b1;
            s1_color_next = {alpha, red_next, green_next, blue_next};
            col_inc       = {1'b0, col_next} + (DIM_W+1)'(1);
            col_next      = DIM_W'(col_inc);
            if (col_inc >= {1'b0, dim_w})
            begin
                col_next = '0;
                row_inc  = {1'b0, row_next} + (DIM_W+1)'(1);
                row_next = DIM_W'(row_inc);
                pad_next = row_pad;
                if (row_inc >= {1'b0, dim_h})
                begin
                    s1_done_next = 1'b1;
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BLUE;
            blue_reg    <= '0;
            green_reg   <= '0;
            red_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
            stopped_reg <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            red_reg     <= red_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
            stopped_reg <= stopped_next;
        end
    end

    // result stage valid
    always_comb
    begin
        if (in_acc)
            s1_valid_next = emit;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_color_reg <= s1_color_next;
            s1_done_reg  <= s1_done_next;
            s1_err_reg   <= s1_err_next;
        end
    end

    // clip and framebuffer address
    always_comb
    begin
        logic              on_screen;
        logic [PROD_W-1:0] addr_full;
        on_screen = (s1_x_reg >= 0) && (s1_x_reg < SCR_W_S) &&
                    (s1_y_reg >= 0) && (s1_y_reg < SCR_H_S);
        addr_full = PROD_W'(s1_y_reg[SCR_COORD_W-1:0]) * PROD_W'(SCREEN_WIDTH)
                    + PROD_W'(s1_x_reg[SCR_COORD_W-1:0]);
        out_color_next = s1_color_reg;
        if (s1_err_reg)
        begin
            out_status_next = ST_BAD_DEPTH;
            out_addr_next   = '0;
            out_color_next  = '0;
        end
        else if (on_screen)
        begin
            out_status_next = ST_WRITE;
            out_addr_next   = addr_full[ADDR_W-1:0];
        end
        else
        begin
            out_status_next = ST_CLIPPED;
            out_addr_next   = '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_slot)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_addr_reg   <= out_addr_next;
            out_color_reg  <= out_color_next;
            out_status_reg <= out_status_next;
            out_done_reg   <= s1_done_reg;
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.fb_address  = out_addr_reg;
    assign pixel_out.pixel_color = out_color_reg;
    assign pixel_out.status      = out_status_reg;
    assign pixel_out.image_done  = out_done_reg;

    // checks
    `BMP_ASSERT_NOW(a_err_ends_image, s1_valid_reg && s1_err_reg, s1_done_reg)
    `BMP_ASSERT_NEXT(a_err_stops, in_acc && emit && s1_err_next, stopped_reg)
    `BMP_ASSERT_NOW(a_bad_depth_beat, out_valid_reg && (out_status_reg == ST_BAD_DEPTH), out_done_reg && (out_color_reg == '0) && (out_addr_reg == '0))

endmodule
